>>> hdl/assert_macros.svh
// assertion macros for the checker file rpa_checker.sv
// needs signals named clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset, generic message
`define RPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rpa assertion failed");

// same check with a caller-supplied message string
`define RPA_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

>>> hdl/rpa_pkg.sv
// shared types, constants and helper functions of the pixel to ascii ramp block
// no dependencies
package rpa_pkg;

    localparam int MAX_ROW_WIDTH = 4096;
    localparam int REPEAT_COUNT  = 3;
    localparam int RAMP_LEVELS   = 10;

    localparam int SAMPLE_W    = 8;
    localparam int ROW_W       = 13;
    localparam int CHAR_W      = 7;
    localparam int COL_W       = $clog2(MAX_ROW_WIDTH);
    localparam int IDX_W       = $clog2(RAMP_LEVELS);
    localparam int LUMA_W      = 8;
    localparam int REM_W       = 12;
    localparam int PROD_W      = 24;
    localparam int STEP_W      = $clog2(IDX_W);
    localparam int REP_W       = $clog2(REPEAT_COUNT + 1);
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // luma weights, 16-bit fixed point, summing to 65536
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;
    localparam logic [IDX_W-1:0]  TOP_INDEX    = IDX_W'(RAMP_LEVELS - 1);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SAMPLE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH  = CFG_INDEX_W'(1);

    // classified pixel: ramp index and end-of-row mark
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             row_end;
    } cls_t;

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } div_state_t;

    // brightness ramp " .:-=+*%@#"
    function automatic logic [CHAR_W-1:0] ramp_code(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] code;
        case (idx)
            4'd0:    code = 7'd32;
            4'd1:    code = 7'd46;
            4'd2:    code = 7'd58;
            4'd3:    code = 7'd45;
            4'd4:    code = 7'd61;
            4'd5:    code = 7'd43;
            4'd6:    code = 7'd42;
            4'd7:    code = 7'd37;
            4'd8:    code = 7'd64;
            default: code = 7'd35;
        endcase
        return code;
    endfunction

    // zero width acts as one, oversize widths clip to the maximum
    function automatic logic [ROW_W-1:0] eff_width(input logic [ROW_W-1:0] w);
        logic [ROW_W-1:0] res;
        res = w;
        if (w == '0)
            res = ROW_W'(1);
        else if (int'(w) > MAX_ROW_WIDTH)
            res = ROW_W'(MAX_ROW_WIDTH);
        return res;
    endfunction

endpackage

>>> hdl/rpa_if.sv
// channel interfaces: pixel input, character output, configuration write
// depends on rpa_pkg
interface rpa_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [rpa_pkg::SAMPLE_W-1:0]  red;
    logic [rpa_pkg::SAMPLE_W-1:0]  green;
    logic [rpa_pkg::SAMPLE_W-1:0]  blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rpa_char_if;
    logic                        valid;
    logic                        ready;
    logic [rpa_pkg::CHAR_W-1:0]  char_code;
    logic                        last_of_pixel;

    modport source (output valid, char_code, last_of_pixel, input ready);
    modport sink   (input valid, char_code, last_of_pixel, output ready);
endinterface

interface rpa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rpa_pkg::CFG_INDEX_W-1:0]  index;
    logic [rpa_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/rpa_div.sv
// ramp index divider: (luma * 10) / max_sample, one quotient bit per cycle
// clamps to the top ramp level when luma reaches max_sample; depends on rpa_pkg
module rpa_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start_valid,
    output logic                         start_ready,
    input  logic [rpa_pkg::LUMA_W-1:0]   luma,
    input  logic                         row_end,
    input  logic [rpa_pkg::SAMPLE_W-1:0] max_sample,
    output logic                         res_valid,
    output rpa_pkg::cls_t                res,
    input  logic                         res_ready
);

    rpa_pkg::div_state_t              state_reg, state_next;
    logic [rpa_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [rpa_pkg::IDX_W-1:0]        quo_reg, quo_next;
    logic [rpa_pkg::STEP_W-1:0]       step_reg, step_next;
    logic                             row_end_reg, row_end_next;
    logic                             start_fire;
    logic                             ld_clamp;
    logic [rpa_pkg::REM_W-1:0]        ld_rem;
    logic [rpa_pkg::REM_W-1:0]        dsh;

    assign start_ready = (state_reg == rpa_pkg::DIV_IDLE)
                      || ((state_reg == rpa_pkg::DIV_DONE) && res_ready);
    assign start_fire  = start_valid && start_ready;

    // luma at or above the divisor (zero divisor too) gives the top level
    assign ld_clamp = ({1'b0, luma} >= {1'b0, max_sample});
    // luma * 10 as shift and add
    assign ld_rem   = (rpa_pkg::REM_W'(luma) << 3) + (rpa_pkg::REM_W'(luma) << 1);
    // divisor aligned to the current quotient bit
    assign dsh      = rpa_pkg::REM_W'(max_sample) << step_reg;

    // sequencer and restoring step
    always_comb
    begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        row_end_next = row_end_reg;
        case (state_reg)
            rpa_pkg::DIV_RUN:
            begin
                if (rem_reg >= dsh)
                begin
                    rem_next           = rem_reg - dsh;
                    quo_next[step_reg] = 1'b1;
                end
                if (step_reg == '0)
                    state_next = rpa_pkg::DIV_DONE;
                else
                    step_next = step_reg - rpa_pkg::STEP_W'(1);
            end
            rpa_pkg::DIV_DONE:
            begin
                if (res_ready)
                    state_next = rpa_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = rpa_pkg::DIV_IDLE;
            end
        endcase
        // new operand, from idle or straight after a handed-off result
        if (start_fire)
        begin
            row_end_next = row_end;
            rem_next     = ld_rem;
            step_next    = rpa_pkg::STEP_W'(rpa_pkg::IDX_W - 1);
            if (ld_clamp)
            begin
                quo_next   = rpa_pkg::TOP_INDEX;
                state_next = rpa_pkg::DIV_DONE;
            end
            else
            begin
                quo_next   = '0;
                state_next = rpa_pkg::DIV_RUN;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rpa_pkg::DIV_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        row_end_reg <= row_end_next;
    end

    assign res_valid   = (state_reg == rpa_pkg::DIV_DONE);
    assign res.idx     = quo_reg;
    assign res.row_end = row_end_reg;

endmodule

>>> hdl/rpa_front.sv
// front end: accepts pixels, computes luma, tracks the column, classifies
// depends on rpa_pkg, rpa_if and rpa_div
module rpa_front (
    input  logic                         clk,
    input  logic                         rst_n,
    rpa_pixel_if.sink                    pixel,
    input  logic [rpa_pkg::SAMPLE_W-1:0] max_sample,
    input  logic [rpa_pkg::ROW_W-1:0]    row_width,
    output logic                         cls_valid,
    output rpa_pkg::cls_t                cls,
    input  logic                         cls_ready
);

    logic [rpa_pkg::COL_W-1:0]   col_reg, col_next;
    logic                        p_valid_reg, p_valid_next;
    logic [rpa_pkg::PROD_W-1:0]  prod_r_reg, prod_g_reg, prod_b_reg;
    logic                        p_row_end_reg;
    logic                        l_valid_reg, l_valid_next;
    logic [rpa_pkg::LUMA_W-1:0]  luma_reg;
    logic                        l_row_end_reg;
    logic                        accept;
    logic                        row_end_now;
    logic [rpa_pkg::PROD_W-1:0]  luma_sum;
    logic                        div_ready;
    logic                        l_take, l_free, p_move, p_free;

    // stage handoff
    assign l_take      = l_valid_reg && div_ready;
    assign l_free      = !l_valid_reg || l_take;
    assign p_move      = p_valid_reg && l_free;
    assign p_free      = !p_valid_reg || p_move;
    assign pixel.ready = p_free;
    assign accept      = pixel.valid && p_free;

    // end of row when this pixel fills the effective width
    assign row_end_now = (rpa_pkg::ROW_W'(col_reg) + rpa_pkg::ROW_W'(1))
                      >= rpa_pkg::eff_width(row_width);

    always_comb
    begin
        col_next = col_reg;
        if (accept)
        begin
            if (row_end_now)
                col_next = '0;
            else
                col_next = col_reg + rpa_pkg::COL_W'(1);
        end
    end

    assign p_valid_next = accept ? 1'b1 : (p_move ? 1'b0 : p_valid_reg);
    assign l_valid_next = p_move ? 1'b1 : (l_take ? 1'b0 : l_valid_reg);

    // weighted sum; top byte is the luma
    assign luma_sum = prod_r_reg + prod_g_reg + prod_b_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            p_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            p_valid_reg <= p_valid_next;
            l_valid_reg <= l_valid_next;
        end
    end

    // product stage and luma stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_r_reg    <= rpa_pkg::PROD_W'(rpa_pkg::COEF_R) * rpa_pkg::PROD_W'(pixel.red);
            prod_g_reg    <= rpa_pkg::PROD_W'(rpa_pkg::COEF_G) * rpa_pkg::PROD_W'(pixel.green);
            prod_b_reg    <= rpa_pkg::PROD_W'(rpa_pkg::COEF_B) * rpa_pkg::PROD_W'(pixel.blue);
            p_row_end_reg <= row_end_now;
        end
        if (p_move)
        begin
            luma_reg      <= luma_sum[rpa_pkg::PROD_W-1 -: rpa_pkg::LUMA_W];
            l_row_end_reg <= p_row_end_reg;
        end
    end

    rpa_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_valid (l_valid_reg),
        .start_ready (div_ready),
        .luma        (luma_reg),
        .row_end     (l_row_end_reg),
        .max_sample  (max_sample),
        .res_valid   (cls_valid),
        .res         (cls),
        .res_ready   (cls_ready)
    );

endmodule

>>> hdl/rpa_fifo.sv
// short queue of classified pixels between front and back end
// depends on rpa_pkg
module rpa_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rpa_pkg::cls_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rpa_pkg::cls_t  pop_data
);

    rpa_pkg::cls_t              mem_reg [rpa_pkg::QUEUE_DEPTH];
    logic [rpa_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rpa_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rpa_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       push, pop;

    assign push_ready = (count_reg != rpa_pkg::CNT_W'(rpa_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == rpa_pkg::PTR_W'(rpa_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + rpa_pkg::PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == rpa_pkg::PTR_W'(rpa_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + rpa_pkg::PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + rpa_pkg::CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - rpa_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hdl/rpa_back.sv
// back end: emits the ramp character repeatedly, then a newline at row end
// depends on rpa_pkg and rpa_if
module rpa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  rpa_pkg::cls_t  q_data,
    rpa_char_if.source     chars
);

    logic                         cur_valid_reg, cur_valid_next;
    logic [rpa_pkg::CHAR_W-1:0]   cur_code_reg;
    logic                         cur_row_end_reg;
    logic [rpa_pkg::REP_W-1:0]    rep_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [rpa_pkg::CHAR_W-1:0]   out_char_reg;
    logic                         out_last_reg;
    logic                         load_out, is_nl, slot_last, cur_done, cur_free, pop;
    logic [rpa_pkg::CHAR_W-1:0]   slot_char;

    // output register takes the next character when empty or being drained
    assign load_out  = cur_valid_reg && (!out_valid_reg || chars.ready);
    assign is_nl     = (rep_reg == rpa_pkg::REP_W'(rpa_pkg::REPEAT_COUNT));
    assign slot_char = is_nl ? rpa_pkg::NEWLINE_CODE : cur_code_reg;
    assign slot_last = is_nl
                    || ((rep_reg == rpa_pkg::REP_W'(rpa_pkg::REPEAT_COUNT - 1))
                        && !cur_row_end_reg);
    assign cur_done  = load_out && slot_last;
    assign cur_free  = !cur_valid_reg || cur_done;
    assign q_ready   = cur_free;
    assign pop       = q_valid && cur_free;

    assign cur_valid_next = pop ? 1'b1 : (cur_done ? 1'b0 : cur_valid_reg);
    assign out_valid_next = load_out ? 1'b1 : (chars.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // current pixel and character slot counter
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_code_reg    <= rpa_pkg::ramp_code(q_data.idx);
            cur_row_end_reg <= q_data.row_end;
            rep_reg         <= '0;
        end
        else if (load_out)
        begin
            rep_reg <= rep_reg + rpa_pkg::REP_W'(1);
        end
        if (load_out)
        begin
            out_char_reg <= slot_char;
            out_last_reg <= slot_last;
        end
    end

    assign chars.valid         = out_valid_reg;
    assign chars.char_code     = out_char_reg;
    assign chars.last_of_pixel = out_last_reg;

endmodule

>>> hdl/rgb_pixel_to_ascii_ramp.sv
// top level of the pixel to ascii ramp block: front end, queue and back end; needs rpa_pkg, rpa_if
// path: product stage, luma stage, divider, queue, back end pixel register, output register
// the divider takes no new pixel until it hands off its result; its 4-step quotient loop, skipped
//   when luma reaches max_sample, bounds the pixel rate; 3 or 4 characters leave per pixel
// reset: rst_n async active low clears column count, queue and handshakes;
//   max_sample returns to 255 and row_width to 640
module rgb_pixel_to_ascii_ramp (
    input  logic        clk,
    input  logic        rst_n,
    rpa_pixel_if.sink   pixel,
    rpa_char_if.source  chars,
    rpa_cfg_if.sink     cfg
);

    logic [rpa_pkg::SAMPLE_W-1:0]  max_sample_reg, max_sample_next;
    logic [rpa_pkg::ROW_W-1:0]     row_width_reg, row_width_next;
    logic                          cfg_fire;
    logic                          f_valid, f_ready;
    rpa_pkg::cls_t                 f_data;
    logic                          q_valid, q_ready;
    rpa_pkg::cls_t                 q_data;

    // configuration writes, unknown indexes ignored
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    always_comb
    begin
        max_sample_next = max_sample_reg;
        row_width_next  = row_width_reg;
        if (cfg_fire)
        begin
            case (cfg.index)
                rpa_pkg::CFG_MAX_SAMPLE: max_sample_next = cfg.data[rpa_pkg::SAMPLE_W-1:0];
                rpa_pkg::CFG_ROW_WIDTH:  row_width_next  = cfg.data[rpa_pkg::ROW_W-1:0];
                default:                 max_sample_next = max_sample_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sample_reg <= rpa_pkg::SAMPLE_W'(255);
            row_width_reg  <= rpa_pkg::ROW_W'(640);
        end
        else
        begin
            max_sample_reg <= max_sample_next;
            row_width_reg  <= row_width_next;
        end
    end

    // classify
    rpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .max_sample (max_sample_reg),
        .row_width  (row_width_reg),
        .cls_valid  (f_valid),
        .cls        (f_data),
        .cls_ready  (f_ready)
    );

    // decoupling queue
    rpa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // emit characters
    rpa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .chars   (chars)
    );

endmodule

>>> hdl/rpa_checker.sv
// port-level checks on the character output, bound to the top level
// depends on rpa_pkg and assert_macros.svh
`include "assert_macros.svh"

module rpa_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        chars_valid,
    input  logic                        chars_ready,
    input  logic [rpa_pkg::CHAR_W-1:0]  char_code,
    input  logic                        last_of_pixel
);

    // a stalled character holds
    `RPA_ASSERT(a_out_hold, chars_valid && !chars_ready |=> chars_valid && $stable(char_code) && $stable(last_of_pixel))

    // a newline always closes its pixel
    `RPA_ASSERT_MSG(a_nl_last, chars_valid && (char_code == rpa_pkg::NEWLINE_CODE) |-> last_of_pixel, "newline not marked last of pixel")

    // characters of one pixel leave without a gap
    `RPA_ASSERT_MSG(a_no_gap, chars_valid && chars_ready && !last_of_pixel |=> chars_valid, "gap inside a pixel's characters")

endmodule

bind rgb_pixel_to_ascii_ramp rpa_checker u_rpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .chars_valid   (chars.valid),
    .chars_ready   (chars.ready),
    .char_code     (chars.char_code),
    .last_of_pixel (chars.last_of_pixel)
);

>>> dv/ramp_char_checker.sv
`timescale 1ns / 100ps
// scoreboard for rgb_pixel_to_ascii_ramp: tracks register writes, predicts the characters
// of every pixel transaction and compares them with the character channel
// depends on rpa_pkg and the channel interfaces of rpa_if
module ramp_char_checker (
    input  logic   clk,
    input  logic   rst_n,
    rpa_pixel_if   pixel,
    rpa_char_if    chars,
    rpa_cfg_if     cfg,
    output int     failures,
    output int     outstanding
);

    typedef struct packed {
        logic [rpa_pkg::CHAR_W-1:0] code;
        logic                       last;
    } ramp_char_t;

    // brightness ramp, darkest level in the leftmost byte
    localparam logic [8*rpa_pkg::RAMP_LEVELS-1:0] RAMP_TEXT = " .:-=+*%@#";

    logic [rpa_pkg::SAMPLE_W-1:0] max_sample_copy = 8'd255;
    logic [rpa_pkg::ROW_W-1:0]    row_width_copy  = 13'd640;
    int unsigned                  column_pos      = 0;
    ramp_char_t                   expected_chars[$];
    int                           mismatches      = 0;

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        int unsigned                luma;
        int unsigned                level;
        int unsigned                width;
        int                         rep;
        logic                       row_end;
        logic [rpa_pkg::CHAR_W-1:0] code;
        ramp_char_t                 want;
        if (!rst_n)
        begin
            max_sample_copy = 8'd255;
            row_width_copy  = 13'd640;
            column_pos      = 0;
            expected_chars.delete();
            outstanding <= 0;
        end
        else
        begin
            // register write, indexes past the list are dropped
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == rpa_pkg::CFG_MAX_SAMPLE)
                    max_sample_copy = cfg.data[rpa_pkg::SAMPLE_W-1:0];
                else if (cfg.index == rpa_pkg::CFG_ROW_WIDTH)
                    row_width_copy = cfg.data;
            end

            // pixel transaction: luma, ramp level, repeated character and row end
            if (pixel.valid && pixel.ready)
            begin
                luma = (32'(rpa_pkg::COEF_R) * pixel.red + 32'(rpa_pkg::COEF_G) * pixel.green
                        + 32'(rpa_pkg::COEF_B) * pixel.blue) >> 16;
                if (max_sample_copy == '0)
                    level = rpa_pkg::RAMP_LEVELS - 1;
                else
                begin
                    level = (luma * rpa_pkg::RAMP_LEVELS) / max_sample_copy;
                    if (level > rpa_pkg::RAMP_LEVELS - 1)
                        level = rpa_pkg::RAMP_LEVELS - 1;
                end
                code = RAMP_TEXT[8 * (rpa_pkg::RAMP_LEVELS - 1 - level) +: rpa_pkg::CHAR_W];

                width = 32'(row_width_copy);
                if (width == 0)
                    width = 1;
                else if (width > rpa_pkg::MAX_ROW_WIDTH)
                    width = rpa_pkg::MAX_ROW_WIDTH;
                row_end = (column_pos + 1 >= width);

                for (rep = 0; rep < rpa_pkg::REPEAT_COUNT; rep++)
                begin
                    want.code = code;
                    want.last = !row_end && (rep == rpa_pkg::REPEAT_COUNT - 1);
                    expected_chars.push_back(want);
                end
                if (row_end)
                begin
                    want.code = rpa_pkg::NEWLINE_CODE;
                    want.last = 1'b1;
                    expected_chars.push_back(want);
                    column_pos = 0;
                end
                else
                    column_pos = column_pos + 1;
            end

            // character transaction against the oldest prediction
            if (chars.valid && chars.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected char code %0d last %0b", $realtime,
                                 chars.char_code, chars.last_of_pixel);
                    mismatches++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (chars.char_code !== want.code || chars.last_of_pixel !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: char mismatch, expected code %0d last %0b,",
                                      " got code %0d last %0b"},
                                     $realtime, want.code, want.last,
                                     chars.char_code, chars.last_of_pixel);
                        mismatches++;
                    end
                end
            end
            outstanding <= expected_chars.size();
        end
        failures <= mismatches;
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// top of the rgb_pixel_to_ascii_ramp testbench: clock, reset, pixel and register stimulus,
// receiver back-pressure and the verdict
// depends on rpa_pkg, rpa_if, the block and ramp_char_checker
module tb;

    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 30;
    localparam int JUNK_W       = rpa_pkg::CFG_DATA_W - rpa_pkg::SAMPLE_W;
    localparam logic [rpa_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_FIRST =
        rpa_pkg::CFG_ROW_WIDTH + 1'b1;
    localparam logic [rpa_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LAST  = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rpa_pixel_if pixel_ch();
    rpa_char_if  char_ch();
    rpa_cfg_if   cfg_ch();

    int check_failures;
    int chars_pending;

    rgb_pixel_to_ascii_ramp dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .chars (char_ch),
        .cfg   (cfg_ch)
    );

    ramp_char_checker char_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel_ch),
        .chars       (char_ch),
        .cfg         (cfg_ch),
        .failures    (check_failures),
        .outstanding (chars_pending)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: long hold on request, otherwise always ready or a rotating stall pattern
    bit          stall_on   = 1'b0;
    int          hold_asks  = 0;
    int          holds_done = 0;
    int          hold_left  = 0;
    logic [15:0] stall_bits = 16'hA5C3;
    logic [5:0]  stall_age  = '0;

    always @(posedge clk)
    begin
        stall_age <= stall_age + 1'b1;
        if (hold_left > 0)
        begin
            char_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (holds_done != hold_asks)
        begin
            char_ch.ready <= 1'b0;
            hold_left     <= LONG_HOLD - 1;
            holds_done    <= holds_done + 1;
        end
        else if (!stall_on)
            char_ch.ready <= 1'b1;
        else
        begin
            char_ch.ready <= stall_bits[0];
            stall_bits    <= (stall_age == '0) ? (16'($urandom) | 16'h8001)
                                               : {stall_bits[0], stall_bits[15:1]};
        end
    end

    // watchdog on cycles with no transaction on any channel
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((pixel_ch.valid && pixel_ch.ready) || (char_ch.valid && char_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // offer one pixel and hold it until taken, valid stays high afterwards
    task automatic send_pixel(input logic [rpa_pkg::SAMPLE_W-1:0] r,
                              input logic [rpa_pkg::SAMPLE_W-1:0] g,
                              input logic [rpa_pkg::SAMPLE_W-1:0] b);
        pixel_ch.valid <= 1'b1;
        pixel_ch.red   <= r;
        pixel_ch.green <= g;
        pixel_ch.blue  <= b;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
    endtask

    // wait until every predicted character has been taken
    task automatic wait_drained();
        do
            @(posedge clk);
        while (chars_pending != 0);
    endtask

    // register write on an idle block
    task automatic set_reg(input logic [rpa_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rpa_pkg::CFG_DATA_W-1:0] value);
        pixel_ch.valid <= 1'b0;
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // one setting of the registers followed by random pixels sent in bursts
    task automatic run_phase(input int max_val, input int width_val, input int count,
                             input bit gaps_on, input bit stalls_on, input int hold_at);
        logic [rpa_pkg::SAMPLE_W-1:0] r;
        logic [rpa_pkg::SAMPLE_W-1:0] g;
        logic [rpa_pkg::SAMPLE_W-1:0] b;
        logic [JUNK_W-1:0]            high_junk;
        int                           burst_left;
        int                           pick;
        high_junk = JUNK_W'($urandom);
        set_reg(rpa_pkg::CFG_MAX_SAMPLE, {high_junk, max_val[rpa_pkg::SAMPLE_W-1:0]});
        set_reg(rpa_pkg::CFG_ROW_WIDTH, width_val[rpa_pkg::CFG_DATA_W-1:0]);
        if ($urandom_range(0, 1) == 1)
            set_reg(rpa_pkg::CFG_INDEX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                    rpa_pkg::CFG_DATA_W'($urandom));
        stall_on   <= stalls_on;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                if (gaps_on)
                begin
                    pixel_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
            burst_left--;
            if (n == hold_at)
                hold_asks <= hold_asks + 1;
            // mostly uniform samples, some gray levels, some saturated channels
            pick = $urandom_range(0, 19);
            if (pick < 12)
            begin
                r = rpa_pkg::SAMPLE_W'($urandom);
                g = rpa_pkg::SAMPLE_W'($urandom);
                b = rpa_pkg::SAMPLE_W'($urandom);
            end
            else if (pick < 17)
            begin
                r = rpa_pkg::SAMPLE_W'($urandom);
                g = r;
                b = r;
            end
            else
            begin
                r = ($urandom_range(0, 1) == 1) ? '1 : '0;
                g = ($urandom_range(0, 1) == 1) ? '1 : '0;
                b = ($urandom_range(0, 1) == 1) ? '1 : '0;
            end
            send_pixel(r, g, b);
        end
    endtask

    initial
    begin
        pixel_ch.valid = 1'b0;
        pixel_ch.red   = '0;
        pixel_ch.green = '0;
        pixel_ch.blue  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        char_ch.ready  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: black, full brightness clamp, primaries, mid gray
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);

        // zero divisor gives the last ramp level
        set_reg(rpa_pkg::CFG_MAX_SAMPLE, 13'h0000);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd77, 8'd150, 8'd29);

        // zero width ends a row after every pixel
        set_reg(rpa_pkg::CFG_ROW_WIDTH, 13'd0);
        send_pixel(8'd10, 8'd20, 8'd30);
        send_pixel(8'd200, 8'd100, 8'd50);

        // oversized width clips to the maximum row
        set_reg(rpa_pkg::CFG_ROW_WIDTH, 13'h1FFF);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd250, 8'd251, 8'd252);

        // width lowered to the current column, next pixel ends the row
        set_reg(rpa_pkg::CFG_ROW_WIDTH, 13'd2);
        send_pixel(8'd64, 8'd64, 8'd64);
        send_pixel(8'd32, 8'd96, 8'd160);

        // writes past the register list change nothing
        set_reg(CFG_UNUSED_FIRST, 13'd1);
        set_reg(CFG_UNUSED_LAST, 13'h1FFF);
        send_pixel(8'd17, 8'd34, 8'd51);
        send_pixel(8'd255, 8'd254, 8'd253);

        // smallest divisor, upper data bits ignored
        set_reg(rpa_pkg::CFG_MAX_SAMPLE, 13'h1F01);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd2, 8'd0);
        send_pixel(8'd3, 8'd3, 8'd3);

        // random part over several register settings
        run_phase(255, 1, 70, 1'b1, 1'b1, -1);
        run_phase(1, 3, 60, 1'b0, 1'b0, -1);
        run_phase($urandom_range(2, 254), $urandom_range(2, 20), 70, 1'b1, 1'b1, 12);
        run_phase(0, 0, 50, 1'b1, 1'b0, -1);
        run_phase($urandom_range(1, 255), 4096, 20, 1'b1, 1'b1, -1);
        run_phase(255, $urandom_range(5, 40), 80, 1'b1, 1'b0, -1);
        run_phase($urandom_range(1, 255), $urandom_range(1, 12), 70, 1'b0, 1'b1, -1);

        pixel_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (check_failures == 0 && chars_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/rpa_pkg.sv
hdl/rpa_if.sv
hdl/rpa_div.sv
hdl/rpa_front.sv
hdl/rpa_fifo.sv
hdl/rpa_back.sv
hdl/rgb_pixel_to_ascii_ramp.sv
hdl/rpa_checker.sv
dv/ramp_char_checker.sv
dv/tb.sv
